[src/lca_pkg.sv]
// Package for the binary-lifting lowest common ancestor block.
// Holds the transaction field widths, the operation codes and the controller state type.
// No dependencies.
package lca_pkg;

	localparam int FUNC_W = 2;
	localparam int NODE_W = 11;

	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FN_EDGE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_BUILD = 2'd2;
	localparam logic [FUNC_W-1:0] FN_QUERY = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_CLR,
		S_ERA, S_EWA, S_ERB, S_EWB,
		S_BRS, S_BRC, S_BROOT, S_BDEQ, S_BU, S_BUD, S_BKRD, S_BKWR,
		S_BEHD, S_BEH2, S_BECK, S_BEV,
		S_QDA, S_QDB, S_QSW, S_QL, S_QLW, S_QEQ, S_QJR, S_QJU, S_QJV,
		S_QFR, S_QFW, S_QOUT
	} lca_state_t;

endpackage

[src/lca_in_if.sv]
// Request channel of the lowest common ancestor block.
// Depends on lca_pkg for the field widths.
interface lca_in_if import lca_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;
	logic [NODE_W-1:0] node_count;

	modport source (output valid, func, node_a, node_b, node_count, input ready);
	modport sink   (input valid, func, node_a, node_b, node_count, output ready);
endinterface

[src/lca_out_if.sv]
// Response channel of the lowest common ancestor block.
// Depends on lca_pkg for the field width.
interface lca_out_if import lca_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] ancestor;

	modport source (output valid, ancestor, input ready);
	modport sink   (input valid, ancestor, output ready);
endinterface

[src/lca_ram.sv]
// Simple dual-port synchronous memory: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address. No dependencies.
module lca_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/tree_lca_binary_lifting.sv]
// Top level of the binary-lifting lowest common ancestor block.
// Depends on lca_pkg, lca_in_if, lca_out_if and lca_ram.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    func, node_a, node_b, node_count
//  rsp      out  valid/ready    ancestor (one per query)
//
// One transaction is worked on at a time; req.ready is high only while the controller idles.
// Clear is a sweep over the list heads and child marks; the same sweep runs after reset.
// The ancestor table has a single read port, so a query reads its entries one at a time.
// A finished answer waits in the output register; a stalled rsp only holds off the next query.
module tree_lca_binary_lifting import lca_pkg::*; #(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS    = 10
) (
	input logic       clk,
	input logic       arst_n,
	lca_in_if.sink    req,
	lca_out_if.source rsp
);

	localparam int EDGE_CAP = 2 * MAX_NODES;
	localparam int NW  = $clog2(MAX_NODES + 1);
	localparam int CW  = $clog2(MAX_NODES + 2);
	localparam int EW  = $clog2(EDGE_CAP + 1);
	localparam int EAW = $clog2(EDGE_CAP);
	localparam int QW  = $clog2(MAX_NODES);
	localparam int DW  = $clog2(MAX_NODES);
	localparam int LCW = $clog2(LEVELS + 1);
	localparam int AN_DEPTH = (MAX_NODES + 1) * LEVELS;
	localparam int AW  = $clog2(AN_DEPTH);

	lca_state_t state_q, state_d;

	logic [CW-1:0]     idx_q, idx_d;
	logic [NW-1:0]     tsize_q, tsize_d;
	logic [EW-1:0]     ec_q, ec_d;
	logic [NW:0]       head_q, head_d, tail_q, tail_d;
	logic              out_v_q, out_v_d;
	logic [NODE_W-1:0] out_anc_q, out_anc_d;

	logic [NW-1:0]  a_q, a_d, b_q, b_d, u_q, u_d, v_q, v_d;
	logic [NW-1:0]  par_q, par_d, x_q, x_d, au_q, au_d, res_q, res_d;
	logic [DW-1:0]  dep_q, dep_d, da_q, da_d, det_q, det_d;
	logic [LCW-1:0] k_q, k_d;
	logic [EW-1:0]  e_q, e_d;

	logic          hd_we, mk_we, mk_wd, mk_rd, eg_we, dp_we, an_we, qu_we;
	logic [NW-1:0] hd_wa, hd_ra, mk_wa, mk_ra, dp_wa, dp_ra;
	logic [EW-1:0] hd_wd, hd_rd, nx_wd, nx_rd;
	logic [EAW-1:0] eg_wa, eg_ra;
	logic [NW-1:0] tg_wd, tg_rd, an_wd, an_rd, qu_wd, qu_rd;
	logic [DW-1:0] dp_wd, dp_rd;
	logic [AW-1:0] an_wa, an_ra;
	logic [QW-1:0] qu_wa, qu_ra;

	logic a_ok, b_ok;

	function automatic logic [AW-1:0] an_addr(logic [NW-1:0] n, logic [LCW-1:0] l);
		return AW'(AW'(n) * AW'(LEVELS)) + AW'(l);
	endfunction

	lca_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(EW)) u_head (.clk, .we(hd_we), .waddr(hd_wa),
		.wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
	lca_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(1)) u_mark (.clk, .we(mk_we), .waddr(mk_wa),
		.wdata(mk_wd), .raddr(mk_ra), .rdata(mk_rd));
	lca_ram #(.DEPTH(EDGE_CAP), .WIDTH(NW)) u_target (.clk, .we(eg_we), .waddr(eg_wa),
		.wdata(tg_wd), .raddr(eg_ra), .rdata(tg_rd));
	lca_ram #(.DEPTH(EDGE_CAP), .WIDTH(EW)) u_next (.clk, .we(eg_we), .waddr(eg_wa),
		.wdata(nx_wd), .raddr(eg_ra), .rdata(nx_rd));
	lca_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(DW)) u_depth (.clk, .we(dp_we), .waddr(dp_wa),
		.wdata(dp_wd), .raddr(dp_ra), .rdata(dp_rd));
	lca_ram #(.DEPTH(AN_DEPTH), .WIDTH(NW)) u_anc (.clk, .we(an_we), .waddr(an_wa),
		.wdata(an_wd), .raddr(an_ra), .rdata(an_rd));
	lca_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_queue (.clk, .we(qu_we), .waddr(qu_wa),
		.wdata(qu_wd), .raddr(qu_ra), .rdata(qu_rd));

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = out_v_q;
	assign rsp.ancestor = out_anc_q;

	assign a_ok = ({21'b0, req.node_a} <= 32'(MAX_NODES));
	assign b_ok = ({21'b0, req.node_b} <= 32'(MAX_NODES));

	always_comb begin
		state_d = state_q;
		idx_d = idx_q; tsize_d = tsize_q; ec_d = ec_q;
		head_d = head_q; tail_d = tail_q;
		out_v_d = out_v_q; out_anc_d = out_anc_q;
		a_d = a_q; b_d = b_q; u_d = u_q; v_d = v_q;
		par_d = par_q; x_d = x_q; au_d = au_q; res_d = res_q;
		dep_d = dep_q; da_d = da_q; det_d = det_q; k_d = k_q; e_d = e_q;

		hd_we = 1'b0; hd_wa = a_q; hd_wd = EW'(ec_q); hd_ra = a_q;
		mk_we = 1'b0; mk_wa = b_q; mk_wd = 1'b1; mk_ra = NW'(idx_q);
		eg_we = 1'b0; eg_wa = EAW'(ec_q); tg_wd = b_q; nx_wd = hd_rd; eg_ra = EAW'(e_q);
		dp_we = 1'b0; dp_wa = tg_rd; dp_wd = DW'(dep_q + 1'b1); dp_ra = a_q;
		an_we = 1'b0; an_wa = an_addr(tg_rd, '0); an_wd = u_q; an_ra = an_addr(u_q, k_q);
		qu_we = 1'b0; qu_wa = QW'(tail_q); qu_wd = tg_rd; qu_ra = QW'(head_q);

		if (out_v_q && rsp.ready) begin
			out_v_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					a_d = NW'(req.node_a);
					b_d = NW'(req.node_b);
					case (req.func)
						FN_CLEAR: begin
							tsize_d = ({21'b0, req.node_count} > 32'(MAX_NODES)) ?
								NW'(MAX_NODES) : NW'(req.node_count);
							idx_d = '0;
							ec_d = '0;
							state_d = S_CLR;
						end
						FN_EDGE: state_d = (a_ok && b_ok) ? S_ERA : S_IDLE;
						FN_BUILD: begin
							idx_d = CW'(1);
							state_d = S_BRS;
						end
						FN_QUERY: begin
							res_d = '0;
							state_d = (a_ok && b_ok) ? S_QDA : S_QOUT;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CLR: begin
				hd_we = 1'b1; hd_wa = NW'(idx_q); hd_wd = EW'(EDGE_CAP);
				mk_we = 1'b1; mk_wa = NW'(idx_q); mk_wd = 1'b0;
				idx_d = idx_q + 1'b1;
				if (idx_q == CW'(MAX_NODES)) begin
					state_d = S_IDLE;
				end
			end
			// Each edge is stored both ways; the second head read follows the first
			// write so that a self-loop sees its own first entry.
			S_ERA: begin
				hd_ra = a_q;
				state_d = S_EWA;
			end
			S_EWA: begin
				if (ec_q < EW'(EDGE_CAP)) begin
					eg_we = 1'b1; tg_wd = b_q;
					hd_we = 1'b1; hd_wa = a_q;
					ec_d = ec_q + 1'b1;
				end
				state_d = S_ERB;
			end
			S_ERB: begin
				hd_ra = b_q;
				state_d = S_EWB;
			end
			S_EWB: begin
				if (ec_q < EW'(EDGE_CAP)) begin
					eg_we = 1'b1; tg_wd = a_q;
					hd_we = 1'b1; hd_wa = b_q;
					ec_d = ec_q + 1'b1;
				end
				mk_we = 1'b1;
				state_d = S_IDLE;
			end
			S_BRS: begin
				mk_ra = NW'(idx_q);
				state_d = (idx_q > CW'(tsize_q)) ? S_IDLE : S_BRC;
			end
			S_BRC: begin
				if (!mk_rd) begin
					state_d = S_BROOT;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_BRS;
				end
			end
			S_BROOT: begin
				dp_we = 1'b1; dp_wa = NW'(idx_q); dp_wd = '0;
				an_we = 1'b1; an_wa = an_addr(NW'(idx_q), '0); an_wd = NW'(idx_q);
				qu_we = 1'b1; qu_wa = '0; qu_wd = NW'(idx_q);
				head_d = '0;
				tail_d = (NW+1)'(1);
				state_d = S_BDEQ;
			end
			S_BDEQ: begin
				qu_ra = QW'(head_q);
				head_d = head_q + 1'b1;
				state_d = S_BU;
			end
			S_BU: begin
				u_d = qu_rd;
				dp_ra = qu_rd;
				an_ra = an_addr(qu_rd, '0);
				state_d = S_BUD;
			end
			S_BUD: begin
				dep_d = dp_rd;
				par_d = an_rd;
				x_d = an_rd;
				k_d = LCW'(1);
				state_d = (LEVELS > 1) ? S_BKRD : S_BEHD;
			end
			S_BKRD: begin
				an_ra = an_addr(x_q, LCW'(k_q - 1'b1));
				state_d = S_BKWR;
			end
			S_BKWR: begin
				an_we = 1'b1; an_wa = an_addr(u_q, k_q); an_wd = an_rd;
				x_d = an_rd;
				k_d = k_q + 1'b1;
				state_d = (k_q == LCW'(LEVELS - 1)) ? S_BEHD : S_BKRD;
			end
			S_BEHD: begin
				hd_ra = u_q;
				state_d = S_BEH2;
			end
			S_BEH2: begin
				e_d = hd_rd;
				state_d = S_BECK;
			end
			S_BECK: begin
				eg_ra = EAW'(e_q);
				if (e_q >= EW'(EDGE_CAP)) begin
					state_d = (head_q < tail_q) ? S_BDEQ : S_IDLE;
				end else begin
					state_d = S_BEV;
				end
			end
			S_BEV: begin
				e_d = nx_rd;
				if (tg_rd != par_q && tail_q < (NW+1)'(MAX_NODES)) begin
					dp_we = 1'b1;
					an_we = 1'b1;
					qu_we = 1'b1;
					tail_d = tail_q + 1'b1;
					// A self-loop rewrites this node's own parent and depth.
					if (tg_rd == u_q) begin
						par_d = u_q;
						dep_d = DW'(dep_q + 1'b1);
					end
				end
				state_d = S_BECK;
			end
			S_QDA: begin
				dp_ra = a_q;
				state_d = S_QDB;
			end
			S_QDB: begin
				da_d = dp_rd;
				dp_ra = b_q;
				state_d = S_QSW;
			end
			S_QSW: begin
				if (da_q > dp_rd) begin
					u_d = b_q; v_d = a_q; det_d = da_q - dp_rd;
				end else begin
					u_d = a_q; v_d = b_q; det_d = dp_rd - da_q;
				end
				k_d = '0;
				state_d = S_QL;
			end
			S_QL: begin
				an_ra = an_addr(v_q, k_q);
				if (det_q == '0 || k_q == LCW'(LEVELS)) begin
					state_d = S_QEQ;
				end else if (det_q[0]) begin
					state_d = S_QLW;
				end else begin
					det_d = det_q >> 1;
					k_d = k_q + 1'b1;
				end
			end
			S_QLW: begin
				v_d = an_rd;
				det_d = det_q >> 1;
				k_d = k_q + 1'b1;
				state_d = S_QL;
			end
			S_QEQ: begin
				res_d = u_q;
				k_d = LCW'(LEVELS - 1);
				state_d = (u_q == v_q) ? S_QOUT : S_QJR;
			end
			S_QJR: begin
				an_ra = an_addr(u_q, k_q);
				state_d = S_QJU;
			end
			S_QJU: begin
				au_d = an_rd;
				an_ra = an_addr(v_q, k_q);
				state_d = S_QJV;
			end
			S_QJV: begin
				if (au_q != an_rd) begin
					u_d = au_q;
					v_d = an_rd;
				end
				if (k_q == '0) begin
					state_d = S_QFR;
				end else begin
					k_d = k_q - 1'b1;
					state_d = S_QJR;
				end
			end
			S_QFR: begin
				an_ra = an_addr(u_q, '0);
				state_d = S_QFW;
			end
			S_QFW: begin
				res_d = an_rd;
				state_d = S_QOUT;
			end
			S_QOUT: begin
				if (!out_v_q || rsp.ready) begin
					out_v_d = 1'b1;
					out_anc_d = NODE_W'(res_q);
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q   <= '0;
			tsize_q <= '0;
			ec_q    <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			tsize_q <= tsize_d;
			ec_q    <= ec_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			out_v_q <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		out_anc_q <= out_anc_d;
		a_q <= a_d; b_q <= b_d; u_q <= u_d; v_q <= v_d;
		par_q <= par_d; x_q <= x_d; au_q <= au_d; res_q <= res_d;
		dep_q <= dep_d; da_q <= da_d; det_q <= det_d; k_q <= k_d; e_q <= e_d;
	end

	a_edge_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ec_q <= EW'(EDGE_CAP))
		else $error("edge count beyond the edge store");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q && tail_q <= (NW+1)'(MAX_NODES))
		else $error("visit queue pointers out of order");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == S_QOUT))
		else $error("response raised outside the query path");

endmodule
